// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the packet scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define TDFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tdfs assertion failed");
// Condition that must never be true outside reset.
`define TDFS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tdfs forbidden condition seen");
`else
`define TDFS_ASSERT(lbl, clk, rst_n, prop)
`define TDFS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/tdfs_pkg.sv =====
// Package with widths, reset values and controller/datapath interface types.
package tdfs_pkg;

  localparam int unsigned MaxEntriesDefault = 64;
  localparam int unsigned ArrW  = 32;
  localparam int unsigned ProcW = 16;
  localparam int unsigned TimeW = 40;
  localparam int unsigned SizeW = 7;
  localparam logic [SizeW-1:0] BufSizeReset = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic retire;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic retire_ok;
  } dp_status_t;

endpackage

// ===== hw/rtl/tail_drop_fifo_packet_scheduler_core.sv =====
// Tail-drop FIFO packet scheduler: one packet in, one drop flag and start time out.
// A packet transaction is taken in while the block is idle, then retires every stored finish
// time that is due from the front of the queue, one per cycle, since the head entry is read
// from the finish-time RAM through its registered read port, and then hands off its result;
// a waiting result holds the block back only when the next one is ready to leave.
// Results come out in packet order. A dropped packet reports start time 0.
// Buffer size is written through cfg_we_i/cfg_wdata_i; the user must write it only while
// the block is idle, which the block itself does not enforce. It resets to 64 and saturates at
// MaxEntries; a size of zero drops every packet. The finish-time store needs no clearing after reset.
module tail_drop_fifo_packet_scheduler_core #(
  parameter int unsigned MaxEntries = tdfs_pkg::MaxEntriesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tdfs_pkg::SizeW-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // Bits 31:0 arrival_time, bits 47:32 process_time.
  input  logic [47:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // Bits 39:0 start_time.
  output logic [39:0]                m_axis_tdata,
  // Bit 0 dropped.
  output logic [0:0]                 m_axis_tuser
);
  import tdfs_pkg::*;

`include "assert_macros.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       dropped;

  tdfs_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tdfs_datapath #(
    .MaxEntries (MaxEntries)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .arrival_time_i (s_axis_tdata[ArrW-1:0]),
    .process_time_i (s_axis_tdata[ArrW+ProcW-1:ArrW]),
    .cmd_i          (cmd),
    .status_o       (status),
    .dropped_o      (dropped),
    .start_time_o   (m_axis_tdata)
  );

  assign m_axis_tuser = dropped;

  // A retirement only ever happens on a non-empty queue.
  `TDFS_ASSERT_NEVER(a_retire_empty, clk_i, rst_ni, cmd.retire && status.empty)
  // Retiring and finishing a packet are exclusive in one cycle.
  `TDFS_ASSERT_NEVER(a_retire_finish, clk_i, rst_ni, cmd.retire && cmd.finish)
  // An accepted packet is worked on before the next one is taken.
  `TDFS_ASSERT(a_one_at_a_time, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  // A dropped packet always reports start time zero.
  `TDFS_ASSERT(a_drop_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))

endmodule

// ===== hw/rtl/tdfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tdfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tdfs_datapath.sv =====
// Datapath: finish-time store, queue pointers, input latch and result register.
module tdfs_datapath #(
  parameter int unsigned MaxEntries = tdfs_pkg::MaxEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tdfs_pkg::SizeW-1:0]    cfg_wdata_i,
  input  logic [tdfs_pkg::ArrW-1:0]     arrival_time_i,
  input  logic [tdfs_pkg::ProcW-1:0]    process_time_i,
  input  tdfs_pkg::ctrl_cmd_t           cmd_i,
  output tdfs_pkg::dp_status_t          status_o,
  output logic                          dropped_o,
  output logic [tdfs_pkg::TimeW-1:0]    start_time_o
);
  import tdfs_pkg::*;

  localparam int unsigned AddrW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW  = $clog2(MaxEntries + 1);
  localparam int unsigned CmpW  = (CntW > SizeW) ? CntW : SizeW;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(MaxEntries - 1);
  localparam logic [CmpW-1:0]  MaxCmp  = CmpW'(MaxEntries);

  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d, head_next, tail_next, rd_addr;
  logic [CntW-1:0]  count_q, count_d;
  logic [SizeW-1:0] bs_q;
  logic [ArrW-1:0]  arr_q;
  logic [ProcW-1:0] proc_q;
  logic [TimeW-1:0] tail_time_q, head_time;
  logic [TimeW-1:0] start_time, finish_time;
  logic [TimeW-1:0] out_start_q;
  logic             out_drop_q;
  logic [CmpW-1:0]  cap, bs_ext, count_ext;
  logic             empty, full, push;

  // Circular increment of a slot index.
  assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

  // Capacity saturates at the store depth; a size of zero drops everything.
  assign bs_ext    = CmpW'(bs_q);
  assign count_ext = CmpW'(count_q);
  assign cap       = (bs_ext > MaxCmp) ? MaxCmp : bs_ext;
  assign empty     = (count_q == '0);
  assign full      = (count_ext >= cap);

  // Start time follows the newest finish time unless the queue is empty.
  assign start_time  = empty ? TimeW'(arr_q) : tail_time_q;
  assign finish_time = start_time + TimeW'(proc_q);
  assign push        = cmd_i.finish && !full;

  // Read the head entry; step ahead while retiring so the data keeps pace.
  assign rd_addr = cmd_i.retire ? head_next : head_q;

  tdfs_ram #(
    .Width (TimeW),
    .Depth (MaxEntries)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (tail_q),
    .wdata_i (finish_time),
    .raddr_i (rd_addr),
    .rdata_o (head_time)
  );

  assign status_o.empty     = empty;
  assign status_o.retire_ok = !empty && (head_time <= TimeW'(arr_q));

  // Pointer and count updates.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.retire) begin
      head_d  = head_next;
      count_d = count_q - 1'b1;
    end else if (push) begin
      tail_d  = tail_next;
      count_d = count_q + 1'b1;
    end
  end

  // Control state of the queue and the buffer size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      bs_q    <= BufSizeReset;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        bs_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: input latch, newest finish time and the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      arr_q  <= arrival_time_i;
      proc_q <= process_time_i;
    end
    if (push) begin
      tail_time_q <= finish_time;
    end
    if (cmd_i.finish) begin
      out_drop_q  <= full;
      out_start_q <= full ? '0 : start_time;
    end
  end

  assign dropped_o    = out_drop_q;
  assign start_time_o = out_start_q;

endmodule

// ===== hw/rtl/tdfs_controller.sv =====
// Controller: sequences input acceptance, retirement and result hand-off.
module tdfs_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  tdfs_pkg::dp_status_t  status_i,
  output tdfs_pkg::ctrl_cmd_t   cmd_o
);
  import tdfs_pkg::*;

  typedef enum logic {
    StIdle,
    StCheck
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.latch_in = 1'b0;
    cmd_o.retire   = 1'b0;
    cmd_o.finish   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = StCheck;
        end
      end
      StCheck: begin
        if (status_i.retire_ok) begin
          cmd_o.retire = 1'b1;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and the registered result-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/tb_tail_drop_fifo_packet_scheduler_core.sv =====
// Self-checking testbench for the tail-drop FIFO packet scheduler core.
module tb_tail_drop_fifo_packet_scheduler_core;

  import tdfs_pkg::*;

  localparam int unsigned QueueDepth   = MaxEntriesDefault;
  localparam int unsigned RandomItems  = 1800;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned MaxReports   = 40;

  // One scheduling decision as the block reports it.
  typedef struct packed {
    logic             dropped;
    logic [TimeW-1:0] start_time;
  } sched_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [SizeW-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Bits 31:0 arrival_time, bits 47:32 process_time.
  logic [ArrW+ProcW-1:0] s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Bits 39:0 start_time.
  logic [TimeW-1:0]      m_axis_tdata;
  // Bit 0 dropped.
  logic [0:0]            m_axis_tuser;

  // Shadow copy of the scheduler state.
  logic [TimeW-1:0] finish_store [QueueDepth];
  int unsigned      head_slot   = 0;
  int unsigned      occupancy   = 0;
  logic [SizeW-1:0] buffer_size = BufSizeReset;

  sched_result_t    expected_results [$];

  int unsigned error_count    = 0;
  int unsigned sent_count     = 0;
  int unsigned drop_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned settings_count = 0;
  int unsigned cycle_count    = 0;

  // Sender burst control and running packet clock.
  int unsigned      tx_burst_left = 0;
  bit               tx_no_gaps    = 1'b0;
  logic [ArrW-1:0]  time_base     = 32'd400000;

  // Receiver stall pattern state.
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold      = 0;
  int unsigned rx_tick      = 0;

  tail_drop_fifo_packet_scheduler_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Retire finished packets, then either drop the new one or queue its finish time.
  function automatic sched_result_t schedule_packet(input logic [ArrW-1:0]  arrival,
                                                    input logic [ProcW-1:0] proc);
    sched_result_t    res;
    int unsigned      limit;
    logic [TimeW-1:0] start;
    while (occupancy != 0 && finish_store[head_slot] <= {8'd0, arrival}) begin
      head_slot = (head_slot + 1) % QueueDepth;
      occupancy--;
    end
    limit = (buffer_size > QueueDepth) ? QueueDepth : buffer_size;
    if (occupancy >= limit) begin
      res.dropped    = 1'b1;
      res.start_time = '0;
      drop_count++;
    end else begin
      if (occupancy == 0) start = {8'd0, arrival};
      else                start = finish_store[(head_slot + occupancy - 1) % QueueDepth];
      finish_store[(head_slot + occupancy) % QueueDepth] = start + {24'd0, proc};
      occupancy++;
      res.dropped    = 1'b0;
      res.start_time = start;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MaxReports) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Offer one packet and record its expected result once the transaction completes.
  task automatic send_packet(input logic [ArrW-1:0] arrival, input logic [ProcW-1:0] proc);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {proc, arrival};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(schedule_packet(arrival, proc));
    sent_count++;
    if (tx_burst_left != 0) begin
      tx_burst_left--;
    end else begin
      tx_burst_left = $urandom_range(0, 15);
      if (!tx_no_gaps) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_until_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // The register is only written once the block has gone quiet.
  task automatic set_buffer_size(input logic [SizeW-1:0] new_size);
    s_axis_tvalid <= 1'b0;
    wait_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= new_size;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    buffer_size = new_size;
    settings_count++;
  endtask

  // Reset size of 64, zero and full process times, and an arrival that goes backwards.
  task automatic test_reset_capacity();
    send_packet(32'd0, 16'd0);
    send_packet(32'd0, 16'hFFFF);
    send_packet(32'd0, 16'd1);
    send_packet(32'd10, 16'h8000);
    send_packet(32'd65535, 16'd5);
    send_packet(32'd3, 16'd7);
    send_packet(32'd200000, 16'd2);
  endtask

  // A size of zero drops every packet.
  task automatic test_zero_size();
    set_buffer_size(7'd0);
    send_packet(32'd250000, 16'd1);
    send_packet(32'd250000, 16'd0);
    send_packet(32'd260000, 16'hFFFF);
  endtask

  // One slot: a second packet is dropped until the first finishes exactly on time.
  task automatic test_single_slot();
    set_buffer_size(7'd1);
    send_packet(32'd300000, 16'd10);
    send_packet(32'd300005, 16'd3);
    send_packet(32'd300010, 16'd7);
    send_packet(32'd300010, 16'd0);
  endtask

  // Sizes above the store depth saturate.
  task automatic test_oversized_sizes();
    set_buffer_size(7'd127);
    send_packet(32'd310000, 16'd100);
    send_packet(32'd310000, 16'd100);
    send_packet(32'd310001, 16'd0);
    set_buffer_size(7'd65);
    send_packet(32'd320000, 16'd50);
    send_packet(32'd320000, 16'd50);
  endtask

  // Phases of random traffic, each with its own buffer size and load.
  task automatic test_random_traffic();
    int unsigned      random_sent;
    int unsigned      phase;
    int unsigned      phase_items;
    int unsigned      load;
    logic [SizeW-1:0] new_size;
    logic [ArrW-1:0]  arrival;
    logic [ProcW-1:0] proc;
    random_sent = 0;
    phase       = 0;
    while (random_sent < RandomItems) begin
      case (phase)
        0: new_size = 7'd127;
        1: new_size = 7'd64;
        2: new_size = 7'd65;
        3: new_size = 7'd0;
        4: new_size = 7'd1;
        default: begin
          case ($urandom_range(0, 6))
            0: new_size = 7'd0;
            1: new_size = 7'd1;
            2: new_size = 7'd2;
            3: new_size = 7'd64;
            4: new_size = 7'(($urandom_range(65, 127)));
            5: new_size = 7'd127;
            default: new_size = 7'(($urandom_range(1, 64)));
          endcase
        end
      endcase
      set_buffer_size(new_size);
      load        = (phase < 5) ? 0 : $urandom_range(0, 3);
      tx_no_gaps  = ($urandom_range(0, 3) == 0);
      phase_items = (new_size == 0) ? 30 : $urandom_range(80, 200);
      // Move the packet clock forward so the whole arrival range is visited.
      if (time_base < 32'hE000_0000) time_base += $urandom_range(0, 32'h1400_0000);
      repeat (phase_items) begin
        case (load)
          0: begin
            time_base += $urandom_range(0, 20);
            proc = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 3000));
          end
          1: begin
            time_base += $urandom_range(0, 1000);
            proc = 16'($urandom_range(0, 1000));
          end
          2: begin
            time_base += $urandom_range(100, 2000);
            proc = 16'($urandom_range(0, 200));
          end
          default: begin
            if ($urandom_range(0, 9) == 0) time_base += $urandom_range(1000, 50000);
            proc = 16'($urandom_range(0, 2000));
          end
        endcase
        arrival = time_base;
        if ($urandom_range(0, 19) == 0) begin
          // Out-of-order arrival: up to 5000 before the packet clock.
          arrival = time_base - $urandom_range(0, 5000);
        end else if ($urandom_range(0, 49) == 0) begin
          // Long silence: the packet clock jumps ahead and due finish times retire.
          time_base += $urandom_range(100000, 1000000);
          arrival = time_base;
        end
        send_packet(arrival, proc);
        random_sent++;
      end
      phase++;
    end
  endtask

  // Arrivals at the top of their range push start times past 32 bits. Such finish
  // times never retire afterwards, so this runs last.
  task automatic test_top_of_time_range();
    set_buffer_size(7'd4);
    send_packet(32'hFFFF_FFF0, 16'hFFFF);
    send_packet(32'hFFFF_FFFF, 16'hFFFF);
    send_packet(32'hFFFF_FFFF, 16'd0);
    send_packet(32'hFFFF_FFFF, 16'hFFFF);
    send_packet(32'hFFFF_FFFF, 16'd1);
  endtask

  // Receiver stalls: always ready, random, periodic and long holds, chosen at random.
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(50, 400);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ((rx_tick % 5) < 2);
      default: begin
        if (rx_hold != 0) begin
          m_axis_tready <= 1'b0;
          rx_hold       <= rx_hold - 1;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, start time %0d",
                                  m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser[0] !== want.dropped)
          report_mismatch($sformatf("dropped %b, expected %b", m_axis_tuser[0], want.dropped));
        if (m_axis_tdata !== want.start_time)
          report_mismatch($sformatf("start time %0d, expected %0d",
                                    m_axis_tdata, want.start_time));
        checked_count++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_capacity();
    test_zero_size();
    test_single_slot();
    test_oversized_sizes();
    test_random_traffic();
    test_top_of_time_range();
    s_axis_tvalid <= 1'b0;
    wait_until_drained();
    $display("Covered %0d packets under %0d buffer size writes; %0d dropped, %0d results checked",
             sent_count, settings_count, drop_count, checked_count);
    $display("Mismatches found: %0d", error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
